// ----- design/sfr_pkg.sv -----
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int unsigned MAX_PAYLOAD = 12;
    localparam logic [7:0]  HEADER_BYTE = 8'h3C;   // '<'

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_FUNC  = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CHECK = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_PENDING = 2'd0,
        ST_GOOD    = 2'd1,
        ST_ERROR   = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0] frame_status;
        logic [7:0] function_code;
        logic [3:0] payload_length;
        logic       payload_valid;
        logic [3:0] payload_index;
        logic [7:0] payload_byte;
        logic [7:0] good_frame_count;
    } t_result;

endpackage

// ----- design/sfr_if.sv -----
`timescale 1ns / 1ps

interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] frame_status;
    logic [7:0] function_code;
    logic [3:0] payload_length;
    logic       payload_valid;
    logic [3:0] payload_index;
    logic [7:0] payload_byte;
    logic [7:0] good_frame_count;

    modport source (
        output valid, output frame_status, output function_code,
        output payload_length, output payload_valid, output payload_index,
        output payload_byte, output good_frame_count, input ready
    );
    modport sink (
        input valid, input frame_status, input function_code,
        input payload_length, input payload_valid, input payload_index,
        input payload_byte, input good_frame_count, output ready
    );
endinterface

// ----- design/sfr_in_stage.sv -----
`timescale 1ns / 1ps

module sfr_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfr_in_if.sink     i_rx,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    logic       r_valid;
    logic [7:0] r_byte;
    logic       w_load;

    // take a new beat when empty or when the held one moves on
    assign i_rx.ready = !r_valid || i_advance;
    assign w_load     = i_rx.valid && i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

// ----- design/sfr_parser.sv -----
`timescale 1ns / 1ps

module sfr_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic [7:0]            i_byte,
    output sfr_pkg::t_result      o_result
);
    import sfr_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_sum, n_sum;
    logic [3:0] r_count, n_count;
    logic [7:0] r_func, n_func;
    logic [3:0] r_len, n_len;
    logic [7:0] r_frames, n_frames;
    logic [3:0] w_count_inc;

    assign w_count_inc = r_count + 4'd1;

    always_comb begin
        n_phase  = r_phase;
        n_sum    = r_sum;
        n_count  = r_count;
        n_func   = r_func;
        n_len    = r_len;
        n_frames = r_frames;
        o_result = '0;
        o_result.frame_status = ST_PENDING;

        unique case (r_phase)
            PH_HUNT: begin
                if (i_byte == HEADER_BYTE) begin
                    n_sum   = i_byte;
                    n_phase = PH_FUNC;
                end
            end
            PH_FUNC: begin
                n_sum   = r_sum + i_byte;
                n_func  = i_byte;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                if (i_byte <= 8'(MAX_PAYLOAD)) begin
                    n_sum   = r_sum + i_byte;
                    n_len   = i_byte[3:0];
                    n_count = 4'd0;
                    n_phase = (i_byte[3:0] == 4'd0) ? PH_CHECK : PH_DATA;
                end else begin
                    // oversized: drop the frame and resync
                    n_sum   = 8'd0;
                    n_phase = PH_HUNT;
                end
            end
            PH_DATA: begin
                n_sum                  = r_sum + i_byte;
                o_result.payload_valid = 1'b1;
                o_result.payload_index = r_count;
                o_result.payload_byte  = i_byte;
                n_count                = w_count_inc;
                if (w_count_inc >= r_len || w_count_inc == 4'd0) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_phase = PH_HUNT;
                n_count = 4'd0;
                if (r_sum == i_byte) begin
                    o_result.frame_status = ST_GOOD;
                    n_frames              = r_frames + 8'd1;
                end else begin
                    o_result.frame_status = ST_ERROR;
                end
            end
            default: begin
                n_phase               = PH_HUNT;
                n_count               = 4'd0;
                o_result.frame_status = ST_ERROR;
            end
        endcase

        o_result.function_code    = n_func;
        o_result.payload_length   = n_len;
        o_result.good_frame_count = n_frames;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_sum    <= 8'd0;
            r_count  <= 4'd0;
            r_func   <= 8'd0;
            r_len    <= 4'd0;
            r_frames <= 8'd0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_sum    <= n_sum;
            r_count  <= n_count;
            r_func   <= n_func;
            r_len    <= n_len;
            r_frames <= n_frames;
        end
    end
endmodule

// ----- design/sfr_out_stage.sv -----
`timescale 1ns / 1ps

module sfr_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  sfr_pkg::t_result i_result,
    output logic             o_advance,
    sfr_out_if.source        o_res
);
    import sfr_pkg::*;

    logic    r_valid;
    t_result r_result;

    // move a beat in when the register is empty or being drained
    assign o_advance = i_valid && (!r_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid            = r_valid;
    assign o_res.frame_status     = r_result.frame_status;
    assign o_res.function_code    = r_result.function_code;
    assign o_res.payload_length   = r_result.payload_length;
    assign o_res.payload_valid    = r_result.payload_valid;
    assign o_res.payload_index    = r_result.payload_index;
    assign o_res.payload_byte     = r_result.payload_byte;
    assign o_res.good_frame_count = r_result.good_frame_count;
endmodule

// ----- design/serial_frame_receiver_top.sv -----
`timescale 1ns / 1ps

// Byte-serial frame receiver: each beat on i_rx carries one received byte and
// gives exactly one beat on o_res. Frames are '<', function, length (0 to
// MAX_PAYLOAD), payload, then a checksum byte equal to the 8-bit sum of all
// bytes before it. Payload bytes come out with their index; the checksum byte
// reports good or error, and good frames bump a wrapping counter. A length
// above MAX_PAYLOAD drops the frame and the parser hunts for '<' again.
// Throughput is one byte per cycle while o_res is ready; an accepted byte passes
// through the input register, the parse logic and the result register.
module serial_frame_receiver_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfr_in_if.sink     i_rx,
    sfr_out_if.source  o_res
);
    import sfr_pkg::*;

    logic       w_advance;
    logic       w_in_valid;
    logic [7:0] w_in_byte;
    t_result    w_result;

    sfr_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_byte    (w_in_byte)
    );

    sfr_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_byte    (w_in_byte),
        .o_result  (w_result)
    );

    sfr_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_in_valid),
        .i_result  (w_result),
        .o_advance (w_advance),
        .o_res     (o_res)
    );
endmodule
